// File: rtl/twma_pkg.sv
package twma_pkg;

  // Ring geometry (DEPTH must be a power of two so ring indexes wrap naturally)
  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int VAL_W      = 32;
  localparam int STAMP_W    = 32;
  localparam int SUM_W      = VAL_W + IDX_W;
  localparam int DIV_STEP_W = $clog2(SUM_W + 1);

  localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd5000;

  typedef struct packed {
    logic [STAMP_W-1:0] timestamp_ms;
    logic [VAL_W-1:0]   sample_value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] average;
    logic [6:0]       sample_count;
  } out_item_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [VAL_W-1:0]   value;
  } ring_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_REPLACE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/time_window_moving_average.sv
// Time-windowed moving average.
// Input channel (in_valid / in_stall / in_data): one transaction per sample,
// carrying its millisecond timestamp and unsigned Q16.16 value. in_stall is
// high while an item is being processed; one item is handled at a time.
// Output channel (out_valid / out_stall / out_data): one transaction per input,
// the Q16.16 mean of the samples inside the window and their count.
// Configuration: cfg_wr_en / cfg_wr_data write window_ms (reset value 5000).
// Processing: the item is inserted into the ring (replacing the oldest entry
// when the ring is full), expired samples are walked out from the oldest end,
// the sum is divided by the held count in the serial divider, and the result
// is loaded into the output register. No new item is taken until the block
// is back in idle.
// Reset (rst, synchronous) empties the ring and clears the sum; ring memory
// contents are not cleared, only held entries are ever read.
// A stalled result is held in the output register; the block may finish the
// next item and then waits with in_stall high until the result is taken.
module time_window_moving_average (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  twma_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output twma_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);
  import twma_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [STAMP_W-1:0] window_ms;
  logic [IDX_W-1:0]   oldest;
  logic [CNT_W-1:0]   held_count;
  logic [SUM_W-1:0]   running_sum;
  logic [STAMP_W-1:0] now;
  logic [VAL_W-1:0]   new_val;

  ring_entry_t        ring_mem [DEPTH];
  ring_entry_t        rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;

  logic               ring_full;
  logic               expire;
  logic [STAMP_W-1:0] age;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   quotient;
  logic               load_out;

  assign ring_full = held_count == CNT_W'(DEPTH);
  assign age       = now - rd_data.stamp;
  assign expire    = age > window_ms;
  assign in_stall  = state != ST_IDLE;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_ms <= cfg_wr_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_INSERT;
      ST_INSERT:  state_next = ring_full ? ST_REPLACE : ST_SCAN_RD;
      ST_REPLACE: state_next = ST_SCAN_RD;
      ST_SCAN_RD: state_next = ST_SCAN;
      ST_SCAN:    if (!expire) state_next = ST_DIVIDE;
      ST_DIVIDE:  if (div_done) state_next = ST_EMIT;
      ST_EMIT:    if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Memory and divider controls
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = oldest;
    rd_addr   = oldest;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_INSERT: begin
        if (!ring_full) begin
          wr_en   = 1'b1;
          wr_addr = oldest + held_count[IDX_W-1:0];
        end
      end
      ST_REPLACE: wr_en = 1'b1;
      ST_SCAN: begin
        // read the next entry ahead so the expiry walk does not wait on the memory
        if (expire) rd_addr = oldest + 1'b1;
        else        div_start = 1'b1;
      end
      ST_EMIT:   load_out = !out_valid || !out_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Ring memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wr_addr] <= '{stamp: now, value: new_val};
    rd_data <= ring_mem[rd_addr];
  end

  // Captured input
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      now     <= in_data.timestamp_ms;
      new_val <= in_data.sample_value;
    end
  end

  // Ring pointers and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest      <= '0;
      held_count  <= '0;
      running_sum <= '0;
    end else begin
      case (state)
        ST_INSERT: begin
          if (!ring_full) begin
            held_count  <= held_count + 1'b1;
            running_sum <= running_sum + SUM_W'(new_val);
          end
        end
        ST_REPLACE: begin
          running_sum <= running_sum - SUM_W'(rd_data.value) + SUM_W'(new_val);
          oldest      <= oldest + 1'b1;
        end
        ST_SCAN: begin
          if (expire) begin
            running_sum <= running_sum - SUM_W'(rd_data.value);
            oldest      <= oldest + 1'b1;
            held_count  <= held_count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  twma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (held_count),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.average      <= quotient[VAL_W-1:0];
      out_data.sample_count <= 7'(held_count);
    end
  end

endmodule

// File: rtl/twma_div.sv
module twma_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [twma_pkg::SUM_W-1:0]  dividend,
  input  logic [twma_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [twma_pkg::SUM_W-1:0]  quotient
);
  import twma_pkg::*;

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [CNT_W-1:0]      rem;
  logic [CNT_W:0]        rem_sh;
  logic                  fits;

  // One quotient bit per cycle, restoring form
  assign rem_sh = {rem, quotient[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift register holds the dividend, then fills with quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], fits};
      rem      <= fits ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
    end
  end

endmodule

// File: rtl/twma_check.sv
module twma_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input twma_pkg::out_item_t out_data
);
  import twma_pkg::*;

  // Every result covers at least the newest sample and at most a full ring
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.sample_count != 7'd0 &&
                   out_data.sample_count <= 7'(DEPTH)))
    else $error("sample_count out of range");

  // One item at a time: a taken transaction closes the input
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after transaction");

  // A sampled reset clears out_valid
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind time_window_moving_average twma_check u_twma_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_data    (out_data)
);
